// ===== hdl/ntx_pkg.sv =====
// ----------------------------------------------------------------------------
// ntx_pkg: shared types and constants of the nearest texel sampler
// Fixed field widths, command and register codes, and the no-texture color.
// ----------------------------------------------------------------------------
package ntx_pkg;

   // fixed field widths
   localparam int COORD_W     = 18;
   localparam int CFG_W       = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int ADDR_W      = 16;
   localparam int STORE_DEPTH = 65536;
   localparam int COLOR_W     = 8;
   localparam int TEXEL_W     = 3 * COLOR_W;

   // item command
   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH     = 2'd0,
      CSR_IMAGE_HEIGHT    = 2'd1,
      CSR_TEXTURE_PRESENT = 2'd2
   } csr_index_type;

   // color answered when no texture is loaded (cyan)
   localparam logic [COLOR_W-1:0] CYAN_RED   = 8'd0;
   localparam logic [COLOR_W-1:0] CYAN_GREEN = 8'd255;
   localparam logic [COLOR_W-1:0] CYAN_BLUE  = 8'd255;

endpackage

// ===== hdl/ntx_req_if.sv =====
// ----------------------------------------------------------------------------
// ntx_req_if: request channel of the nearest texel sampler
// Carries texel writes and sample coordinates under valid/ready.
// ----------------------------------------------------------------------------
interface ntx_req_if
   import ntx_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      command;
   logic signed [COORD_W-1:0] coord_u;
   logic signed [COORD_W-1:0] coord_v;
   logic [ADDR_W-1:0]         write_index;
   logic [COLOR_W-1:0]        write_red;
   logic [COLOR_W-1:0]        write_green;
   logic [COLOR_W-1:0]        write_blue;

   modport source (
      output valid, command, coord_u, coord_v, write_index,
             write_red, write_green, write_blue,
      input  ready
   );

   modport sink (
      input  valid, command, coord_u, coord_v, write_index,
             write_red, write_green, write_blue,
      output ready
   );
endinterface

// ===== hdl/ntx_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ntx_rsp_if: response channel of the nearest texel sampler
// Carries one sampled RGB texel per beat under valid/ready.
// ----------------------------------------------------------------------------
interface ntx_rsp_if
   import ntx_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;

   modport source (
      output valid, red, green, blue,
      input  ready
   );

   modport sink (
      input  valid, red, green, blue,
      output ready
   );
endinterface

// ===== hdl/ntx_ram.sv =====
// ----------------------------------------------------------------------------
// ntx_ram: generic single-port synchronous RAM
// One access per cycle; read data is registered and holds between reads.
// ----------------------------------------------------------------------------
module ntx_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or read one entry
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/nearest_texel_sampler.sv =====
// ----------------------------------------------------------------------------
// nearest_texel_sampler: nearest-neighbor texture lookup over a texel RAM
// Texel writes fill the store; samples map (u,v) to a texel and return it.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one beat per item. command write stores write_red/green/blue at
//          write_index and yields no response. command sample takes coord_u
//          and coord_v (signed, FRACTION_BITS fraction bits), clamps them to
//          [0,1], flips v, and yields one rsp beat with the texel bytes.
//   rsp  : red, green, blue of the selected texel, or cyan (0,255,255) when
//          texture_present is 0.
//   csr  : csr_we writes csr_wdata to register csr_index (0 width, 1 height,
//          2 texture_present); write only while no item is in flight.
// Path: a sample passes stage 1, stage 2, the RAM stage 3 and the output register before rsp offers it.
// Throughput: one item per cycle while rsp does not stall; the single RAM port serves one write or one
//   read each cycle, the two multiplier stages sit ahead of it.
// Ordering: writes and samples reach the RAM in request order, so a sample
//   sees every earlier write.
// Stall: the whole pipeline halts while rsp holds an untaken beat; req.ready
//   is low only then. Reset empties the pipeline and restores width 1,
//   height 1, no texture; texel contents are undefined until written.
// ----------------------------------------------------------------------------
module nearest_texel_sampler
   import ntx_pkg::*;
#(
   parameter int MAX_WIDTH     = 256,
   parameter int MAX_HEIGHT    = 256,
   parameter int FRACTION_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   ntx_req_if.sink              req,
   ntx_rsp_if.source            rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   // derived widths
   localparam int SW = $clog2(MAX_WIDTH + 1);
   localparam int SH = $clog2(MAX_HEIGHT + 1);
   localparam int UW = FRACTION_BITS + 1;
   localparam int CW = (COORD_W > UW + 1) ? COORD_W : UW + 1;
   localparam int PUW = UW + SW;
   localparam int PVW = UW + SH;
   localparam int LW0 = SH + SW + 1;
   localparam int LW = (LW0 > ADDR_W) ? LW0 : ADDR_W;
   localparam logic [UW-1:0] ONE = UW'(1) << FRACTION_BITS;
   localparam logic signed [CW-1:0] ONE_S = CW'(1) << FRACTION_BITS;

   // clamp a signed coordinate to [0, one]
   function automatic logic [UW-1:0] clamp_unit(input logic signed [COORD_W-1:0] x);
      logic signed [CW-1:0] xw;
      xw = CW'(x);
      if (xw < 0) begin
         return '0;
      end else if (xw > ONE_S) begin
         return ONE;
      end else begin
         return UW'(xw);
      end
   endfunction

   // configuration registers
   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic             present_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= CFG_W'(1);
         height_ff  <= CFG_W'(1);
         present_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:     width_ff   <= csr_wdata;
            CSR_IMAGE_HEIGHT:    height_ff  <= csr_wdata;
            CSR_TEXTURE_PRESENT: present_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // saturate sizes to [1, max]
   logic [SW-1:0] w_sat;
   logic [SH-1:0] h_sat;

   always_comb begin
      if (width_ff == '0) begin
         w_sat = SW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_sat = SW'(MAX_WIDTH);
      end else begin
         w_sat = SW'(width_ff);
      end
      if (height_ff == '0) begin
         h_sat = SH'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_sat = SH'(MAX_HEIGHT);
      end else begin
         h_sat = SH'(height_ff);
      end
   end

   // pipeline advances whenever the output register is free or being taken
   logic advance;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   // stage 1: clamp and scale coordinates
   logic [UW-1:0]  u_clamp;
   logic [UW-1:0]  v_flip;
   logic [PUW-1:0] prod_u;
   logic [PVW-1:0] prod_v;
   logic [SW-1:0]  col_in;
   logic [SH-1:0]  row_in;

   always_comb begin
      u_clamp = clamp_unit(req.coord_u);
      v_flip  = ONE - clamp_unit(req.coord_v);
      prod_u  = PUW'(u_clamp) * PUW'(w_sat);
      prod_v  = PVW'(v_flip) * PVW'(h_sat);
      col_in  = prod_u[FRACTION_BITS +: SW];
      row_in  = prod_v[FRACTION_BITS +: SH];
   end

   logic                 valid1_ff;
   logic                 cmd1_ff;
   logic                 present1_ff;
   logic [SW-1:0]        col1_ff;
   logic [SH-1:0]        row1_ff;
   logic [ADDR_W-1:0]    widx1_ff;
   logic [TEXEL_W-1:0]   wdata1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd1_ff     <= req.command;
         present1_ff <= present_ff;
         col1_ff     <= col_in;
         row1_ff     <= row_in;
         widx1_ff    <= req.write_index;
         wdata1_ff   <= {req.write_red, req.write_green, req.write_blue};
      end
   end

   // stage 2: saturate indexes and form the linear address
   logic [SW-1:0]     col_sat;
   logic [SH-1:0]     row_sat;
   logic [LW-1:0]     lin;
   logic [ADDR_W-1:0] addr_in;

   always_comb begin
      col_sat = (col1_ff >= w_sat) ? w_sat - SW'(1) : col1_ff;
      row_sat = (row1_ff >= h_sat) ? h_sat - SH'(1) : row1_ff;
      lin     = LW'(row_sat) * LW'(w_sat) + LW'(col_sat);
      addr_in = (cmd1_ff == CMD_WRITE) ? widx1_ff : lin[ADDR_W-1:0];
   end

   logic                 valid2_ff;
   logic                 cmd2_ff;
   logic                 present2_ff;
   logic [ADDR_W-1:0]    addr2_ff;
   logic [TEXEL_W-1:0]   wdata2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (advance) begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd2_ff     <= cmd1_ff;
         present2_ff <= present1_ff;
         addr2_ff    <= addr_in;
         wdata2_ff   <= wdata1_ff;
      end
   end

   // stage 3: one RAM access in request order
   logic               ram_en;
   logic               ram_we;
   logic [TEXEL_W-1:0] ram_rdata;

   assign ram_en = advance && valid2_ff;
   assign ram_we = (cmd2_ff == CMD_WRITE);

   ntx_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_texel_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (addr2_ff),
      .wdata (wdata2_ff),
      .rdata (ram_rdata)
   );

   logic valid3_ff;
   logic present3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else if (advance) begin
         valid3_ff <= valid2_ff && (cmd2_ff == CMD_SAMPLE);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         present3_ff <= present2_ff;
      end
   end

   // output register: hold the beat until taken
   logic [TEXEL_W-1:0] texel_in;
   logic [TEXEL_W-1:0] texel_ff;

   assign texel_in = present3_ff ? ram_rdata : {CYAN_RED, CYAN_GREEN, CYAN_BLUE};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         texel_ff <= texel_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.red   = texel_ff[2*COLOR_W +: COLOR_W];
   assign rsp.green = texel_ff[COLOR_W +: COLOR_W];
   assign rsp.blue  = texel_ff[0 +: COLOR_W];

   // a texel write never turns into a response
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      advance && valid2_ff && (cmd2_ff == CMD_WRITE) |=> !valid3_ff)
      else $error("texel write produced a response slot");

   // scaled column and row never exceed the width and height before saturation
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      valid1_ff |-> (col1_ff <= w_sat) && (row1_ff <= h_sat))
      else $error("scaled index beyond image size");

   // a new response beat comes only from a filled RAM stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(valid3_ff))
      else $error("response raised without a sample in flight");

   // a stalled pipeline holds its stage 2 and stage 3 valid flags
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid3_ff) && $stable(valid2_ff))
      else $error("pipeline moved during a stall");

endmodule

// ===== tb/nearest_texel_sampler_test.sv =====
// ----------------------------------------------------------------------------
// nearest_texel_sampler_test: self-checking bench for the nearest texel sampler
// Fills the texel store through write beats and checks sample beats against a
// texel lookup model, first from a directed table and then from random phases
// over many image sizes, with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module nearest_texel_sampler_test;
   import ntx_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS    = 16;
   localparam int UNIT         = 1 << FRAC_BITS;
   localparam int SIZE_LIMIT   = 256;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 50;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } texel_type;

   typedef struct packed {
      cmd_type                   command;
      logic signed [COORD_W-1:0] u;
      logic signed [COORD_W-1:0] v;
      logic [ADDR_W-1:0]         index;
      texel_type                 color;
   } req_item_type;

   typedef enum logic [1:0] {
      ROW_CONFIG,
      ROW_WRITE,
      ROW_SAMPLE
   } row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic signed [COORD_W-1:0] u;
      logic signed [COORD_W-1:0] v;
      logic [ADDR_W-1:0]         index;
      texel_type                 color;
      logic                      typed;
      texel_type                 answer;
      logic [CFG_W-1:0]          width;
      logic [CFG_W-1:0]          height;
      logic [CFG_W-1:0]          present;
   } stim_row_type;

   localparam texel_type NO_TEXTURE = '{CYAN_RED, CYAN_GREEN, CYAN_BLUE};

   // directed stimulus: reset state, extremes of the coordinates, clamping,
   // corner texels, out-of-range sizes and texture switched off
   localparam int DIRECTED_ROWS = 24;
   localparam stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_SAMPLE, 18'h00000, 18'h00000, 16'd0,     24'h0, 1'b1, NO_TEXTURE, 9'd0, 9'd0, 9'd0},
      '{ROW_SAMPLE, 18'h1FFFF, 18'h20000, 16'd0,     24'h0, 1'b1, NO_TEXTURE, 9'd0, 9'd0, 9'd0},
      '{ROW_WRITE,  18'h00000, 18'h00000, 16'd0, 24'h123456, 1'b0, 24'h0, 9'd0, 9'd0, 9'd0},
      '{ROW_CONFIG, 18'h00000, 18'h00000, 16'd0,     24'h0, 1'b0, 24'h0, 9'd1, 9'd1, 9'd1},
      '{ROW_SAMPLE, 18'h20000, 18'h1FFFF, 16'd0,     24'h0, 1'b1, 24'h123456, 9'd0, 9'd0, 9'd0},
      '{ROW_SAMPLE, 18'h10000, 18'h00000, 16'd0,     24'h0, 1'b1, 24'h123456, 9'd0, 9'd0, 9'd0},
      '{ROW_CONFIG, 18'h00000, 18'h00000, 16'd0,     24'h0, 1'b0, 24'h0, 9'd256, 9'd256, 9'd1},
      '{ROW_WRITE,  18'h00000, 18'h00000, 16'd0,     24'h000000, 1'b0, 24'h0, 9'd0, 9'd0, 9'd0},
      '{ROW_WRITE,  18'h00000, 18'h00000, 16'd255,   24'hFFFFFF, 1'b0, 24'h0, 9'd0, 9'd0, 9'd0},
      '{ROW_WRITE,  18'h00000, 18'h00000, 16'd65280, 24'h0A0B0C, 1'b0, 24'h0, 9'd0, 9'd0, 9'd0},
      '{ROW_WRITE,  18'h00000, 18'h00000, 16'd65535, 24'hFF0080, 1'b0, 24'h0, 9'd0, 9'd0, 9'd0},
      '{ROW_SAMPLE, 18'h00000, 18'h10000, 16'd0,     24'h0, 1'b1, 24'h000000, 9'd0, 9'd0, 9'd0},
      '{ROW_SAMPLE, 18'h10000, 18'h10000, 16'd0,     24'h0, 1'b1, 24'hFFFFFF, 9'd0, 9'd0, 9'd0},
      '{ROW_SAMPLE, 18'h00000, 18'h00000, 16'd0,     24'h0, 1'b1, 24'h0A0B0C, 9'd0, 9'd0, 9'd0},
      '{ROW_SAMPLE, 18'h1FFFF, 18'h20000, 16'd0,     24'h0, 1'b1, 24'hFF0080, 9'd0, 9'd0, 9'd0},
      '{ROW_SAMPLE, 18'h20000, 18'h1FFFF, 16'd0,     24'h0, 1'b1, 24'h000000, 9'd0, 9'd0, 9'd0},
      '{ROW_WRITE,  18'h00000, 18'h00000, 16'd32896, 24'h5AA53C, 1'b0, 24'h0, 9'd0, 9'd0, 9'd0},
      '{ROW_SAMPLE, 18'h08000, 18'h08000, 16'd0,     24'h0, 1'b0, 24'h0, 9'd0, 9'd0, 9'd0},
      '{ROW_SAMPLE, 18'h0FFFF, 18'h00001, 16'd0,     24'h0, 1'b0, 24'h0, 9'd0, 9'd0, 9'd0},
      '{ROW_CONFIG, 18'h00000, 18'h00000, 16'd0,     24'h0, 1'b0, 24'h0, 9'd0, 9'd511, 9'd1},
      '{ROW_SAMPLE, 18'h10000, 18'h00000, 16'd0,     24'h0, 1'b0, 24'h0, 9'd0, 9'd0, 9'd0},
      '{ROW_CONFIG, 18'h00000, 18'h00000, 16'd0,     24'h0, 1'b0, 24'h0, 9'd256, 9'd256, 9'h1FE},
      '{ROW_SAMPLE, 18'h08000, 18'h08000, 16'd0,     24'h0, 1'b1, NO_TEXTURE, 9'd0, 9'd0, 9'd0},
      '{ROW_WRITE,  18'h00000, 18'h00000, 16'd1,     24'h010203, 1'b0, 24'h0, 9'd0, 9'd0, 9'd0}
   };

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   csr_index_type       csr_index;
   logic [CFG_W-1:0]    csr_wdata;

   ntx_req_if req_bus ();
   ntx_rsp_if rsp_bus ();

   nearest_texel_sampler dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // bench copy of the registers and the texel store
   logic [CFG_W-1:0]   cfg_width   = 9'd1;
   logic [CFG_W-1:0]   cfg_height  = 9'd1;
   logic               cfg_present = 1'b0;
   texel_type          texel_image [STORE_DEPTH];
   bit                 texel_written [STORE_DEPTH];
   texel_type          expected_texels [$];

   int                 error_count  = 0;
   int                 cycle_count  = 0;
   int                 burst_left   = 0;
   int                 stall_tick   = 0;
   int                 stall_mode   = 0;

   always #1 clock = ~clock;

   // size registers saturate to [1, SIZE_LIMIT]
   function automatic int eff_size(input logic [CFG_W-1:0] size);
      if (size == 0)
         return 1;
      if (size > SIZE_LIMIT)
         return SIZE_LIMIT;
      return int'(size);
   endfunction

   // store address that a sample at (u, v) reads under the current image size
   function automatic logic [ADDR_W-1:0] texel_address(input logic signed [COORD_W-1:0] u,
                                                       input logic signed [COORD_W-1:0] v);
      int su;
      int sv;
      int w;
      int h;
      int col;
      int row;
      su = u;
      sv = v;
      su = (su < 0) ? 0 : ((su > UNIT) ? UNIT : su);
      sv = (sv < 0) ? 0 : ((sv > UNIT) ? UNIT : sv);
      sv = UNIT - sv;
      w = eff_size(cfg_width);
      h = eff_size(cfg_height);
      col = (su * w) >> FRAC_BITS;
      row = (sv * h) >> FRAC_BITS;
      if (col >= w)
         col = w - 1;
      if (row >= h)
         row = h - 1;
      return ADDR_W'(row * w + col);
   endfunction

   // drive one request beat in the current burst, then track what it implies
   task automatic push_item(input req_item_type item, input logic typed,
                            input texel_type answer);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.command     <= item.command;
      req_bus.coord_u     <= item.u;
      req_bus.coord_v     <= item.v;
      req_bus.write_index <= item.index;
      req_bus.write_red   <= item.color.red;
      req_bus.write_green <= item.color.green;
      req_bus.write_blue  <= item.color.blue;
      do
         @(posedge clock);
      while (!req_bus.ready);
      // beat accepted: update the store or queue the answer
      if (item.command == CMD_WRITE) begin
         texel_image[item.index]   = item.color;
         texel_written[item.index] = 1'b1;
      end else if (typed) begin
         expected_texels.push_back(answer);
      end else if (!cfg_present) begin
         expected_texels.push_back(NO_TEXTURE);
      end else begin
         expected_texels.push_back(texel_image[texel_address(item.u, item.v)]);
      end
   endtask

   task automatic issue_write(input logic [ADDR_W-1:0] index, input texel_type color);
      req_item_type item;
      item.command = CMD_WRITE;
      item.u       = COORD_W'($urandom);
      item.v       = COORD_W'($urandom);
      item.index   = index;
      item.color   = color;
      push_item(item, 1'b0, '0);
   endtask

   // when a texture is present, fill the target texel first if it was never written
   task automatic issue_sample(input logic signed [COORD_W-1:0] u,
                               input logic signed [COORD_W-1:0] v,
                               input logic typed, input texel_type answer);
      req_item_type      item;
      logic [ADDR_W-1:0] target;
      target = texel_address(u, v);
      if (cfg_present && !texel_written[target])
         issue_write(target, texel_type'($urandom));
      item.command = CMD_SAMPLE;
      item.u       = u;
      item.v       = v;
      item.index   = ADDR_W'($urandom);
      item.color   = texel_type'($urandom);
      push_item(item, typed, answer);
   endtask

   // drop valid, wait for every answer, then let trailing writes retire
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (expected_texels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height,
                               input logic [CFG_W-1:0] present_word);
      csr_index_type    regs [3];
      logic [CFG_W-1:0] values [3];
      regs   = '{CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT, CSR_TEXTURE_PRESENT};
      values = '{width, height, present_word};
      for (int k = 0; k < 3; k++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[k];
         csr_wdata <= values[k];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg_width   = width;
      cfg_height  = height;
      cfg_present = present_word[0];
   endtask

   function automatic logic signed [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 9))
         0, 1, 2: return COORD_W'($urandom);
         3:       return '0;
         4:       return COORD_W'(UNIT);
         default: return COORD_W'($urandom_range(0, UNIT));
      endcase
   endfunction

   // stimulus
   initial begin
      stim_row_type     row;
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] height;
      logic [CFG_W-1:0] present_word;
      int               col;
      int               line;
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= CSR_IMAGE_WIDTH;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.command     <= CMD_WRITE;
      req_bus.coord_u     <= '0;
      req_bus.coord_v     <= '0;
      req_bus.write_index <= '0;
      req_bus.write_red   <= '0;
      req_bus.write_green <= '0;
      req_bus.write_blue  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_rows[i];
         case (row.kind)
            ROW_CONFIG: begin
               wait_drained();
               apply_config(row.width, row.height, row.present);
            end
            ROW_WRITE: issue_write(row.index, row.color);
            default:   issue_sample(row.u, row.v, row.typed, row.answer);
         endcase
      end

      // random phases, each under its own image size
      for (int phase = 0; phase < 10; phase++) begin
         present_word = {8'($urandom), 1'b1};
         case (phase)
            0: begin width = 9'd1;   height = 9'd1;   end
            1: begin width = 9'd256; height = 9'd256; end
            2: begin width = 9'd0;   height = 9'd0;   end
            3: begin width = 9'd511; height = 9'd300; end
            4: begin width = 9'd256; height = 9'd1;   end
            5: begin width = 9'd1;   height = 9'd256; end
            6: begin
               width        = 9'($urandom_range(0, 511));
               height       = 9'($urandom_range(0, 511));
               present_word = {8'($urandom), 1'b0};
            end
            default: begin
               width  = 9'($urandom_range(1, 256));
               height = 9'($urandom_range(1, 40));
            end
         endcase
         wait_drained();
         apply_config(width, height, present_word);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 35) begin
               if ($urandom_range(0, 1) == 0) begin
                  issue_write(ADDR_W'($urandom), texel_type'($urandom));
               end else begin
                  col  = $urandom_range(0, eff_size(cfg_width) - 1);
                  line = $urandom_range(0, eff_size(cfg_height) - 1);
                  issue_write(ADDR_W'(line * eff_size(cfg_width) + col),
                              texel_type'($urandom));
               end
            end else begin
               issue_sample(random_coord(), random_coord(), 1'b0, '0);
            end
         end
      end

      wait_drained();
      if (error_count == 0)
         $display("nearest_texel_sampler test passed");
      else
         $display("nearest_texel_sampler test failed");
      $finish;
   end

   // response side stalls on a pattern that switches between four modes at random
   always @(posedge clock) begin
      stall_tick++;
      if (stall_tick % 64 == 0)
         stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_bus.ready <= 1'b1;
         1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
         2:       rsp_bus.ready <= (stall_tick % 7) >= 2;
         default: rsp_bus.ready <= (stall_tick % 32) < 4;
      endcase
   end

   task automatic check_field(input string name, input logic [COLOR_W-1:0] want,
                              input logic [COLOR_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // compare each response beat with the oldest expected texel
   always @(posedge clock) begin
      texel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_texels.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response beat, expected none, actual %h %h %h",
                     $time, rsp_bus.red, rsp_bus.green, rsp_bus.blue);
         end else begin
            want = expected_texels.pop_front();
            check_field("red", want.red, rsp_bus.red);
            check_field("green", want.green, rsp_bus.green);
            check_field("blue", want.blue, rsp_bus.blue);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("nearest_texel_sampler test failed");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
hdl/ntx_pkg.sv
hdl/ntx_req_if.sv
hdl/ntx_rsp_if.sv
hdl/ntx_ram.sv
hdl/nearest_texel_sampler.sv
tb/nearest_texel_sampler_test.sv
